@@ sv/fpa_pkg.sv @@
// Shared types and constants of the fixed-point ALU.
package fpa_pkg;

    // Operation selector codes.
    localparam logic [4:0] KIND_ADD = 5'd0;
    localparam logic [4:0] KIND_SUB = 5'd1;
    localparam logic [4:0] KIND_MUL = 5'd2;
    localparam logic [4:0] KIND_DIV = 5'd3;
    localparam logic [4:0] KIND_GT  = 5'd4;
    localparam logic [4:0] KIND_LT  = 5'd5;
    localparam logic [4:0] KIND_GE  = 5'd6;
    localparam logic [4:0] KIND_LE  = 5'd7;
    localparam logic [4:0] KIND_EQ  = 5'd8;
    localparam logic [4:0] KIND_NE  = 5'd9;
    localparam logic [4:0] KIND_MIN = 5'd10;
    localparam logic [4:0] KIND_MAX = 5'd11;
    localparam logic [4:0] KIND_INC = 5'd12;
    localparam logic [4:0] KIND_DEC = 5'd13;
    localparam logic [4:0] KIND_I2X = 5'd14;
    localparam logic [4:0] KIND_X2I = 5'd15;
    localparam logic [4:0] KIND_F2X = 5'd16;
    localparam logic [4:0] KIND_X2F = 5'd17;

    // Error codes.
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_DIV_ZERO = 2'd1;
    localparam logic [1:0] ERR_RANGE    = 2'd2;

    // Saturation limits of a 32-bit signed word.
    localparam logic [31:0] WORD_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] WORD_MIN = 32'h8000_0000;

    // Request and response payloads.
    typedef struct packed {
        logic [4:0]  kind;
        logic [31:0] operand_a;
        logic [31:0] operand_b;
    } fpa_req_t;

    typedef struct packed {
        logic [31:0] result_word;
        logic        compare_true;
        logic [1:0]  error_code;
    } fpa_rsp_t;

    // Float conversion results handed to the output stage.
    typedef struct packed {
        logic [31:0] from_res;
        logic [1:0]  from_err;
        logic [31:0] to_res;
    } fpa_flt_t;

endpackage

@@ sv/fpa_dly.sv @@
// Enabled delay line that carries a result to the end of the pipeline.
module fpa_dly #(
    parameter int W = 1,
    parameter int N = 1
) (
    input  logic         clk,
    input  logic [N-1:0] en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    logic [W-1:0] pipe_reg [N];

    // One register per stage, each loading when its stage advances.
    for (genvar i = 0; i < N; i++) begin : g_stage
        if (i == 0) begin : g_first
            always_ff @(posedge clk)
            begin
                if (en[i])
                begin
                    pipe_reg[i] <= d;
                end
            end
        end else begin : g_next
            always_ff @(posedge clk)
            begin
                if (en[i])
                begin
                    pipe_reg[i] <= pipe_reg[i-1];
                end
            end
        end
    end

    assign q = pipe_reg[N-1];

endmodule

@@ sv/fpa_basic.sv @@
// Add, subtract, compare, min, max, increment, decrement and integer conversions.
module fpa_basic #(
    parameter int FRACTION_BITS = 8,
    parameter int NS = 11
) (
    input  logic        clk,
    input  logic [NS:1] en,
    input  logic [4:0]  kind,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [31:0] res,
    output logic        cmp
);
    import fpa_pkg::*;

    logic        lt;
    logic        eq;
    logic [31:0] res1_next;
    logic        cmp1_next;
    logic [31:0] res1_reg;
    logic        cmp1_reg;

    // Combinational operations, registered when the first stage is enabled.
    always_comb
    begin
        lt = $signed(a) < $signed(b);
        eq = (a == b);
        res1_next = '0;
        cmp1_next = 1'b0;
        case (kind)
            KIND_ADD: res1_next = a + b;
            KIND_SUB: res1_next = a - b;
            KIND_GT:  cmp1_next = !lt && !eq;
            KIND_LT:  cmp1_next = lt;
            KIND_GE:  cmp1_next = !lt;
            KIND_LE:  cmp1_next = lt || eq;
            KIND_EQ:  cmp1_next = eq;
            KIND_NE:  cmp1_next = !eq;
            KIND_MIN: res1_next = lt ? a : b;
            KIND_MAX: res1_next = (!lt && !eq) ? a : b;
            KIND_INC: res1_next = a + 32'd1;
            KIND_DEC: res1_next = a - 32'd1;
            KIND_I2X: res1_next = a << FRACTION_BITS;
            KIND_X2I: res1_next = 32'($signed(a) >>> FRACTION_BITS);
            default:  res1_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            res1_reg <= res1_next;
            cmp1_reg <= cmp1_next;
        end
    end

    // Carry the result to the output stage.
    fpa_dly #(.W(33), .N(NS - 1)) u_dly (
        .clk (clk),
        .en  (en[NS:2]),
        .d   ({res1_reg, cmp1_reg}),
        .q   ({res, cmp})
    );

endmodule

@@ sv/fpa_mul.sv @@
// Two-stage signed multiply with the product scaled back by the fraction bits.
module fpa_mul #(
    parameter int FRACTION_BITS = 8,
    parameter int NS = 11
) (
    input  logic        clk,
    input  logic [NS:1] en,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [31:0] res
);

    logic signed [63:0] prod_reg;
    logic [31:0]        res2_reg;

    // Full product, then the arithmetic shift that drops the fraction bits.
    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            prod_reg <= $signed(a) * $signed(b);
        end
        if (en[2])
        begin
            res2_reg <= prod_reg[FRACTION_BITS +: 32];
        end
    end

    fpa_dly #(.W(32), .N(NS - 2)) u_dly (
        .clk (clk),
        .en  (en[NS:3]),
        .d   (res2_reg),
        .q   (res)
    );

endmodule

@@ sv/fpa_div.sv @@
// Pipelined restoring divider, four quotient bits per stage, with rounding.
module fpa_div #(
    parameter int FRACTION_BITS = 8,
    parameter int NS = 11
) (
    input  logic        clk,
    input  logic [NS:1] en,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [31:0] res
);
    import fpa_pkg::*;

    localparam int DS = NS - 1;
    localparam int PW = 4 * DS;
    localparam logic [PW:0] POS_LIM = {{(PW - 31){1'b0}}, WORD_MAX};
    localparam logic [PW:0] NEG_LIM = {{(PW - 31){1'b0}}, WORD_MIN};

    logic [PW-1:0] dq_reg  [0:DS];
    logic [31:0]   rem_reg [0:DS];
    logic [31:0]   nb_reg  [0:DS];
    logic          neg_reg [0:DS];
    logic [PW-1:0] dq_next  [1:DS];
    logic [31:0]   rem_next [1:DS];
    logic [31:0]   abs_a;
    logic [31:0]   abs_b;
    logic          round_up;
    logic [PW:0]   q_rnd;

    assign abs_a = a[31] ? (32'd0 - a) : a;
    assign abs_b = b[31] ? (32'd0 - b) : b;

    // Operand preparation: magnitudes and the scaled dividend.
    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            dq_reg[0]  <= PW'({abs_a, {FRACTION_BITS{1'b0}}});
            rem_reg[0] <= '0;
            nb_reg[0]  <= abs_b;
            neg_reg[0] <= a[31] ^ b[31];
        end
    end

    // Each stage shifts in four dividend bits and settles four quotient bits.
    for (genvar j = 1; j <= DS; j++) begin : g_step
        always_comb
        begin
            logic [32:0]   t;
            logic [31:0]   r;
            logic [PW-1:0] d;
            r = rem_reg[j-1];
            d = dq_reg[j-1];
            for (int k = 0; k < 4; k++)
            begin
                t = {r, d[PW-1]};
                d = {d[PW-2:0], 1'b0};
                if (t >= {1'b0, nb_reg[j-1]})
                begin
                    t = t - {1'b0, nb_reg[j-1]};
                    d[0] = 1'b1;
                end
                r = t[31:0];
            end
            rem_next[j] = r;
            dq_next[j]  = d;
        end

        always_ff @(posedge clk)
        begin
            if (en[j+1])
            begin
                dq_reg[j]  <= dq_next[j];
                rem_reg[j] <= rem_next[j];
                nb_reg[j]  <= nb_reg[j-1];
                neg_reg[j] <= neg_reg[j-1];
            end
        end
    end

    // Round half away from zero, then apply the sign with saturation.
    always_comb
    begin
        round_up = {rem_reg[DS], 1'b0} >= {1'b0, nb_reg[DS]};
        q_rnd = {1'b0, dq_reg[DS]} + (PW + 1)'(round_up);
        if (!neg_reg[DS])
        begin
            res = (q_rnd > POS_LIM) ? WORD_MAX : q_rnd[31:0];
        end
        else
        begin
            res = (q_rnd > NEG_LIM) ? WORD_MIN : (32'd0 - q_rnd[31:0]);
        end
    end

endmodule

@@ sv/fpa_flt.sv @@
// Conversions between fixed point and IEEE single precision.
module fpa_flt #(
    parameter int FRACTION_BITS = 8,
    parameter int NS = 11
) (
    input  logic                clk,
    input  logic [NS:1]         en,
    input  logic [31:0]         a,
    output fpa_pkg::fpa_flt_t   res
);
    import fpa_pkg::*;

    // Float to fixed, stage one: field decode and classification.
    logic [7:0]        f_exp;
    logic [23:0]       f_sig;
    logic signed [9:0] f_sh;
    logic              f1_neg_reg;
    logic              f1_spec_reg;
    logic              f1_nan_reg;
    logic              f1_big_reg;
    logic              f1_tiny_reg;
    logic [23:0]       f1_sig_reg;
    logic signed [9:0] f1_sh_reg;

    always_comb
    begin
        f_exp = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
        f_sig = {(a[30:23] != 8'd0), a[22:0]};
        f_sh  = $signed({2'b00, f_exp}) - 10'sd150 + 10'(FRACTION_BITS);
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            f1_neg_reg  <= a[31];
            f1_spec_reg <= (a[30:23] == 8'hFF);
            f1_nan_reg  <= (a[22:0] != 23'd0);
            f1_big_reg  <= (f_sig != 24'd0) && (f_sh > 10'sd31);
            f1_tiny_reg <= (f_sig == 24'd0) || (f_sh < -10'sd25);
            f1_sig_reg  <= f_sig;
            f1_sh_reg   <= f_sh;
        end
    end

    // Stage two: scale the significand, rounding half away from zero.
    logic [55:0] f_mag;
    logic        f2_neg_reg;
    logic        f2_spec_reg;
    logic        f2_nan_reg;
    logic        f2_big_reg;
    logic [55:0] f2_mag_reg;

    always_comb
    begin
        logic [4:0] rs;
        rs = 5'(-f1_sh_reg);
        if (f1_tiny_reg)
        begin
            f_mag = '0;
        end
        else if (!f1_sh_reg[9])
        begin
            f_mag = 56'(f1_sig_reg) << f1_sh_reg[4:0];
        end
        else
        begin
            f_mag = (56'(f1_sig_reg) + (56'd1 << (rs - 5'd1))) >> rs;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            f2_neg_reg  <= f1_neg_reg;
            f2_spec_reg <= f1_spec_reg;
            f2_nan_reg  <= f1_nan_reg;
            f2_big_reg  <= f1_big_reg;
            f2_mag_reg  <= f_mag;
        end
    end

    // Stage three: signed saturation into a 32-bit word.
    logic [31:0] f_res;
    logic [1:0]  f_err;
    logic [31:0] f3_res_reg;
    logic [1:0]  f3_err_reg;

    always_comb
    begin
        f_err = ERR_NONE;
        if (f2_spec_reg)
        begin
            f_err = ERR_RANGE;
            f_res = f2_nan_reg ? 32'd0 : (f2_neg_reg ? WORD_MIN : WORD_MAX);
        end
        else if (f2_big_reg)
        begin
            f_err = ERR_RANGE;
            f_res = f2_neg_reg ? WORD_MIN : WORD_MAX;
        end
        else if (!f2_neg_reg)
        begin
            if (f2_mag_reg > 56'(WORD_MAX))
            begin
                f_err = ERR_RANGE;
                f_res = WORD_MAX;
            end
            else
            begin
                f_res = f2_mag_reg[31:0];
            end
        end
        else
        begin
            if (f2_mag_reg > 56'(WORD_MIN))
            begin
                f_err = ERR_RANGE;
                f_res = WORD_MIN;
            end
            else
            begin
                f_res = 32'd0 - f2_mag_reg[31:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            f3_res_reg <= f_res;
            f3_err_reg <= f_err;
        end
    end

    // Fixed to float, stage one: sign and magnitude.
    logic        t1_sign_reg;
    logic [31:0] t1_mag_reg;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            t1_sign_reg <= a[31];
            t1_mag_reg  <= a[31] ? (32'd0 - a) : a;
        end
    end

    // Stage two: position of the leading one.
    logic [4:0]  t_msb;
    logic        t2_sign_reg;
    logic        t2_zero_reg;
    logic [4:0]  t2_msb_reg;
    logic [31:0] t2_mag_reg;

    always_comb
    begin
        t_msb = '0;
        for (int i = 0; i < 32; i++)
        begin
            if (t1_mag_reg[i])
            begin
                t_msb = 5'(i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            t2_sign_reg <= t1_sign_reg;
            t2_zero_reg <= (t1_mag_reg == 32'd0);
            t2_msb_reg  <= t_msb;
            t2_mag_reg  <= t1_mag_reg;
        end
    end

    // Stage three: align to 24 bits and decide round to nearest even.
    logic [23:0] t_mant;
    logic        t_rnd;
    logic        t3_sign_reg;
    logic        t3_zero_reg;
    logic [4:0]  t3_msb_reg;
    logic [23:0] t3_mant_reg;
    logic        t3_rnd_reg;

    always_comb
    begin
        logic [4:0]  r;
        logic [31:0] rem;
        logic [31:0] half;
        r = t2_msb_reg - 5'd23;
        rem = t2_mag_reg & ((32'd1 << r) - 32'd1);
        half = 32'd1 << (r - 5'd1);
        if (t2_msb_reg > 5'd23)
        begin
            t_mant = 24'(t2_mag_reg >> r);
            t_rnd  = (rem > half) || ((rem == half) && t_mant[0]);
        end
        else
        begin
            t_mant = 24'(t2_mag_reg << (5'd23 - t2_msb_reg));
            t_rnd  = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            t3_sign_reg <= t2_sign_reg;
            t3_zero_reg <= t2_zero_reg;
            t3_msb_reg  <= t2_msb_reg;
            t3_mant_reg <= t_mant;
            t3_rnd_reg  <= t_rnd;
        end
    end

    // Stage four: apply rounding, renormalize on carry and pack.
    logic [24:0] t_sum;
    logic [5:0]  t_pos;
    logic [7:0]  t_exp;
    logic [31:0] t_res;
    fpa_flt_t    s4_reg;

    always_comb
    begin
        t_sum = {1'b0, t3_mant_reg} + 25'(t3_rnd_reg);
        t_pos = {1'b0, t3_msb_reg} + 6'(t_sum[24]);
        t_exp = 8'(9'(t_pos) + 9'd127 - 9'(FRACTION_BITS));
        if (t3_zero_reg)
        begin
            t_res = '0;
        end
        else
        begin
            t_res = {t3_sign_reg, t_exp, (t_sum[24] ? t_sum[23:1] : t_sum[22:0])};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            s4_reg.from_res <= f3_res_reg;
            s4_reg.from_err <= f3_err_reg;
            s4_reg.to_res   <= t_res;
        end
    end

    fpa_dly #(.W($bits(fpa_flt_t)), .N(NS - 4)) u_dly (
        .clk (clk),
        .en  (en[NS:5]),
        .d   (s4_reg),
        .q   (res)
    );

endmodule

@@ sv/fixed_point_alu_core.sv @@
// A request passes the input capture stage, the execution stages and the output register.
// Throughput: one request per cycle unless stalled; the divider settles four quotient bits per stage.
// Each stage holds its request while the next one cannot advance, so bubbles close up under stall.
// Reset clears only the stage valid bits; datapath registers are not reset.
// Top level of the fixed-point ALU: handshake, stage control and result select.
module fixed_point_alu_core #(
    parameter int FRACTION_BITS = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  fpa_pkg::fpa_req_t req,
    input  logic              req_valid,
    output logic              req_stall,
    output fpa_pkg::fpa_rsp_t rsp,
    output logic              rsp_valid,
    input  logic              rsp_stall
);
    import fpa_pkg::*;

    localparam int QW = 32 + FRACTION_BITS;
    localparam int DS = (QW + 3) / 4;
    localparam int NS = DS + 1;
    localparam int D  = NS + 2;

    logic [D-1:0] v_reg;
    logic [D-1:0] v_next;
    logic [D-1:0] adv;

    // A stage advances when it is empty or the stage after it advances; the last one when rsp_stall is low.
    always_comb
    begin
        adv[D-1] = !v_reg[D-1] || !rsp_stall;
        for (int s = D - 2; s >= 0; s--)
        begin
            adv[s] = !v_reg[s] || adv[s+1];
        end
    end

    always_comb
    begin
        v_next = v_reg;
        if (adv[0])
        begin
            v_next[0] = req_valid;
        end
        for (int s = 1; s < D; s++)
        begin
            if (adv[s])
            begin
                v_next[s] = v_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign req_stall = !adv[0];

    // Input capture stage.
    logic [4:0]  k0_reg;
    logic [31:0] a0_reg;
    logic [31:0] b0_reg;
    logic        bz0_reg;

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            k0_reg  <= req.kind;
            a0_reg  <= req.operand_a;
            b0_reg  <= req.operand_b;
            bz0_reg <= (req.operand_b == 32'd0);
        end
    end

    // Operation code and zero divisor flag ride along with the data.
    logic [4:0] kd;
    logic       bzd;

    fpa_dly #(.W(6), .N(NS)) u_kind_dly (
        .clk (clk),
        .en  (adv[NS:1]),
        .d   ({k0_reg, bz0_reg}),
        .q   ({kd, bzd})
    );

    // Execution units.
    logic [31:0] basic_res;
    logic        basic_cmp;
    logic [31:0] mul_res;
    logic [31:0] div_res;
    fpa_flt_t    flt_res;

    fpa_basic #(.FRACTION_BITS(FRACTION_BITS), .NS(NS)) u_basic (
        .clk  (clk),
        .en   (adv[NS:1]),
        .kind (k0_reg),
        .a    (a0_reg),
        .b    (b0_reg),
        .res  (basic_res),
        .cmp  (basic_cmp)
    );

    fpa_mul #(.FRACTION_BITS(FRACTION_BITS), .NS(NS)) u_mul (
        .clk (clk),
        .en  (adv[NS:1]),
        .a   (a0_reg),
        .b   (b0_reg),
        .res (mul_res)
    );

    fpa_div #(.FRACTION_BITS(FRACTION_BITS), .NS(NS)) u_div (
        .clk (clk),
        .en  (adv[NS:1]),
        .a   (a0_reg),
        .b   (b0_reg),
        .res (div_res)
    );

    fpa_flt #(.FRACTION_BITS(FRACTION_BITS), .NS(NS)) u_flt (
        .clk (clk),
        .en  (adv[NS:1]),
        .a   (a0_reg),
        .res (flt_res)
    );

    // Result select and output register.
    fpa_rsp_t out_next;
    fpa_rsp_t out_reg;

    always_comb
    begin
        out_next = '0;
        case (kd)
            KIND_ADD, KIND_SUB, KIND_MIN, KIND_MAX, KIND_INC, KIND_DEC,
            KIND_I2X, KIND_X2I, KIND_GT, KIND_LT, KIND_GE, KIND_LE,
            KIND_EQ, KIND_NE:
            begin
                out_next.result_word  = basic_res;
                out_next.compare_true = basic_cmp;
            end
            KIND_MUL: out_next.result_word = mul_res;
            KIND_DIV:
            begin
                if (bzd)
                begin
                    out_next.error_code = ERR_DIV_ZERO;
                end
                else
                begin
                    out_next.result_word = div_res;
                end
            end
            KIND_F2X:
            begin
                out_next.result_word = flt_res.from_res;
                out_next.error_code  = flt_res.from_err;
            end
            KIND_X2F: out_next.result_word = flt_res.to_res;
            default:  out_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv[D-1])
        begin
            out_reg <= out_next;
        end
    end

    assign rsp       = out_reg;
    assign rsp_valid = v_reg[D-1];

    // A stalled request port means every stage holds a request.
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> (&v_reg))
        else $error("request stalled while a stage is empty");

    // A request taken with no response leaving adds exactly one occupied stage.
    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall && !(rsp_valid && !rsp_stall))
        |=> ($countones(v_reg) == $past($countones(v_reg)) + 1))
        else $error("request lost or duplicated in pipeline");

    // A response leaving with no new request removes exactly one occupied stage.
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (!(req_valid && !req_stall) && rsp_valid && !rsp_stall)
        |=> ($countones(v_reg) + 1 == $past($countones(v_reg))))
        else $error("response lost or duplicated in pipeline");

    // A true comparison never carries a result word or an error.
    a_cmp_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.compare_true)
        |-> (rsp.result_word == 32'd0 && rsp.error_code == ERR_NONE))
        else $error("compare response carries a result");

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench of the fixed-point ALU core: directed and random requests.
`timescale 1ns / 100ps

module tb_top;
    import fpa_pkg::*;

    localparam int FRAC = 8;
    localparam int LATENCY = 13;
    localparam int CYCLE_LIMIT = 400000;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    fpa_req_t  req = '0;
    logic      req_valid = 1'b0;
    logic      req_stall;
    fpa_rsp_t  rsp;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;

    fpa_rsp_t  pending_rsp[$];
    int        mismatch_count = 0;
    int        cycle_count = 0;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;

    fixed_point_alu_core #(.FRACTION_BITS(FRAC)) dut (
        .clk(clk), .rst_n(rst_n), .req(req), .req_valid(req_valid),
        .req_stall(req_stall), .rsp(rsp), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall)
    );

    always #5 clk = ~clk;

    // Pack a sign and magnitude into a saturated 32-bit word.
    function automatic logic [31:0] clamp_word(input bit neg, input logic [63:0] mag,
                                               output bit clipped);
        clipped = 1'b0;
        if (!neg)
        begin
            if (mag > 64'h7FFF_FFFF)
            begin
                clipped = 1'b1;
                return WORD_MAX;
            end
            return mag[31:0];
        end
        if (mag > 64'h8000_0000)
        begin
            clipped = 1'b1;
            return WORD_MIN;
        end
        return 32'(-mag);
    endfunction

    // IEEE single bits to fixed point, rounding half away from zero.
    function automatic logic [31:0] single_to_fixed(input logic [31:0] bits,
                                                    output logic [1:0] err);
        bit neg;
        logic [7:0] ex;
        logic [63:0] sig, mag;
        int sh, rs;
        bit clipped;
        logic [31:0] res;
        neg = bits[31];
        ex = bits[30:23];
        err = ERR_NONE;
        if (ex == 8'hFF)
        begin
            err = ERR_RANGE;
            if (bits[22:0] != 0) return 32'h0;
            return neg ? WORD_MIN : WORD_MAX;
        end
        sig = (ex == 0) ? {41'b0, bits[22:0]} : {40'b0, 1'b1, bits[22:0]};
        sh = ((ex == 0) ? 1 : int'(ex)) - 150 + FRAC;
        if (sig == 0) mag = 0;
        else if (sh >= 0)
        begin
            if (sh > 31)
            begin
                err = ERR_RANGE;
                return neg ? WORD_MIN : WORD_MAX;
            end
            mag = sig << sh;
        end
        else if (-sh > 25) mag = 0;
        else
        begin
            rs = -sh;
            mag = (sig + (64'd1 << (rs - 1))) >> rs;
        end
        res = clamp_word(neg, mag, clipped);
        if (clipped) err = ERR_RANGE;
        return res;
    endfunction

    // Fixed point to IEEE single, rounding to nearest even.
    function automatic logic [31:0] fixed_to_single(input logic signed [31:0] a);
        logic [63:0] mag, mant, rem, half;
        int p, r;
        logic [7:0] ex;
        if (a == 0) return 32'h0;
        mag = (a < 0) ? -64'(a) : 64'(a);
        p = 0;
        while (p < 63 && (mag >> (p + 1)) != 0) p++;
        if (p > 23)
        begin
            r = p - 23;
            rem = mag & ((64'd1 << r) - 1);
            half = 64'd1 << (r - 1);
            mant = mag >> r;
            if (rem > half || (rem == half && mant[0])) mant++;
            if (mant == (64'd1 << 24))
            begin
                mant >>= 1;
                p++;
            end
        end
        else mant = mag << (23 - p);
        ex = 8'(p - FRAC + 127);
        return {a[31], ex, mant[22:0]};
    endfunction

    // Expected response of the ALU for one request.
    function automatic fpa_rsp_t alu_expect(input fpa_req_t r);
        fpa_rsp_t o;
        logic signed [63:0] a, b, prod;
        logic [63:0] na, nb, q, rm;
        bit clipped;
        logic [1:0] e;
        a = 64'(signed'(r.operand_a));
        b = 64'(signed'(r.operand_b));
        o = '0;
        case (r.kind)
            KIND_ADD: o.result_word = r.operand_a + r.operand_b;
            KIND_SUB: o.result_word = r.operand_a - r.operand_b;
            KIND_MUL:
            begin
                prod = a * b;
                prod = prod >>> FRAC;
                o.result_word = prod[31:0];
            end
            KIND_DIV:
            begin
                if (b == 0) o.error_code = ERR_DIV_ZERO;
                else
                begin
                    na = ((a < 0) ? -a : a) << FRAC;
                    nb = (b < 0) ? -b : b;
                    q = na / nb;
                    rm = na % nb;
                    if (2 * rm >= nb) q++;
                    o.result_word = clamp_word((a < 0) != (b < 0), q, clipped);
                end
            end
            KIND_GT: o.compare_true = a > b;
            KIND_LT: o.compare_true = a < b;
            KIND_GE: o.compare_true = a >= b;
            KIND_LE: o.compare_true = a <= b;
            KIND_EQ: o.compare_true = a == b;
            KIND_NE: o.compare_true = a != b;
            KIND_MIN: o.result_word = (a < b) ? r.operand_a : r.operand_b;
            KIND_MAX: o.result_word = (a > b) ? r.operand_a : r.operand_b;
            KIND_INC: o.result_word = r.operand_a + 1;
            KIND_DEC: o.result_word = r.operand_a - 1;
            KIND_I2X: o.result_word = r.operand_a << FRAC;
            KIND_X2I: o.result_word = 32'(a >>> FRAC);
            KIND_F2X:
            begin
                o.result_word = single_to_fixed(r.operand_a, e);
                o.error_code = e;
            end
            KIND_X2F: o.result_word = fixed_to_single(r.operand_a);
            default: o = '0;
        endcase
        return o;
    endfunction

    // Send one request, with a random gap before it.
    // Valid stays high after acceptance until the next request or an idle cycle replaces it.
    task automatic send_request(input logic [4:0] kind, input logic [31:0] a,
                                input logic [31:0] b);
        fpa_req_t r;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        r.kind = kind;
        r.operand_a = a;
        r.operand_b = b;
        req <= r;
        req_valid <= 1'b1;
        pending_rsp.push_back(alu_expect(r));
        @(posedge clk);
        while (req_stall) @(posedge clk);
    endtask

    // Wait until every expected response has come.
    task automatic drain_responses();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending_rsp.size() != 0) @(posedge clk);
    endtask

    // Random operand biased toward edge values.
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(7))
            0: return WORD_MAX;
            1: return WORD_MIN;
            2: return 32'(signed'($urandom_range(2048)) - 1024);
            3: return 32'h0;
            default: return $urandom();
        endcase
    endfunction

    // Random IEEE single covering subnormal, tiny, normal, huge and special values.
    function automatic logic [31:0] pick_single();
        logic [31:0] f;
        f = $urandom();
        case ($urandom_range(4))
            0: f[30:23] = 8'($urandom_range(100, 160));
            1: f[30:23] = 8'($urandom_range(110, 150));
            2: f[30:23] = ($urandom_range(1)) ? 8'hFF : 8'h00;
            default: ;
        endcase
        return f;
    endfunction

    task automatic test_directed();
        logic [4:0] k;
        // Every operation on extreme operands.
        for (k = KIND_ADD; k <= KIND_X2F; k++)
            send_request(k, WORD_MIN, WORD_MAX);
        // Division by zero, an overflowing quotient and a negative quotient.
        send_request(KIND_DIV, 32'h100, 32'h0);
        send_request(KIND_DIV, WORD_MIN, 32'h1);
        send_request(KIND_DIV, 32'hFFFF_FF80, 32'h100);
        // Float infinity, NaN, too large, tiny and negative zero.
        send_request(KIND_F2X, 32'hFF80_0000, 32'h0);
        send_request(KIND_F2X, 32'h7FC0_0001, 32'h0);
        send_request(KIND_F2X, 32'h4F00_0000, 32'h0);
        send_request(KIND_F2X, 32'h3300_0000, 32'h0);
        send_request(KIND_F2X, 32'h8000_0000, 32'h0);
        // Unused selectors.
        send_request(5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(5'd18, 32'h1234_5678, 32'h0);
        // Sender holds off until the pipeline is empty.
        drain_responses();
    endtask

    task automatic test_random(input int count);
        logic [4:0] k;
        logic [31:0] a;
        for (int i = 0; i < count; i++)
        begin
            k = ($urandom_range(19) == 0) ? 5'($urandom_range(18, 31))
                                           : 5'($urandom_range(0, 17));
            a = (k == KIND_F2X) ? pick_single() : pick_operand();
            send_request(k, a, ($urandom_range(9) == 0) ? $urandom() : pick_operand());
        end
    endtask

    // Receiver stall, sampled fresh each cycle.
    always @(posedge clk)
        rsp_stall <= ($urandom_range(99) < recv_idle_pct);

    // Compare each accepted response with the oldest expectation.
    always @(posedge clk)
    begin
        fpa_rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_rsp.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected response %h", rsp);
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (rsp.result_word !== want.result_word
                    || rsp.compare_true !== want.compare_true
                    || rsp.error_code !== want.error_code)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected word %h cmp %b err %0d, got %h %b %0d",
                                 want.result_word, want.compare_true, want.error_code,
                                 rsp.result_word, rsp.compare_true, rsp.error_code);
                end
            end
        end
    end

    // Watchdog on total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        send_idle_pct = 16;
        recv_idle_pct = 78;
        test_random(310);
        send_idle_pct = 78;
        recv_idle_pct = 16;
        test_random(310);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(310);
        drain_responses();
        repeat (LATENCY + 5) @(posedge clk);
        if (mismatch_count == 0 && pending_rsp.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

@@ filelist.f @@
sv/fpa_pkg.sv
sv/fpa_dly.sv
sv/fpa_basic.sv
sv/fpa_mul.sv
sv/fpa_div.sv
sv/fpa_flt.sv
sv/fixed_point_alu_core.sv
tb/tb_top.sv
